### hw/rtl/sobel_edge_double_threshold_macros.svh
// Assertion macros shared by the edge detector RTL.
// Depends on a clock named clock and an active-high reset named reset in the user.
`ifndef SOBEL_EDGE_DOUBLE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_DOUBLE_THRESHOLD_MACROS_SVH

// same-cycle implication
`define SEDT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/sedt_pkg.sv
// Package for the Sobel edge detector: widths, register codes, per-pixel tags.
// No dependencies; used by sedt_if, sedt_grad and the top level.
`default_nettype none

package sedt_pkg;

   localparam int MAX_WIDTH     = 2048;
   localparam int COL_W         = $clog2(MAX_WIDTH);
   localparam int PIXEL_W       = 8;
   localparam int ROW_W         = 16;
   localparam int COLUMN_W      = 11;
   localparam int IMG_WIDTH_W   = 12;
   localparam int IMG_HEIGHT_W  = 16;
   localparam int THRESH_W      = 11;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int LINE_W        = 2 * PIXEL_W;
   localparam int GRAD_W        = PIXEL_W + 3;
   localparam int SQ_W          = 2 * GRAD_W - 2;
   localparam int MAG_W         = 2 * THRESH_W;

   localparam int WIDTH_RESET   = 2048;
   localparam int HEIGHT_RESET  = 1080;
   localparam int LOW_RESET     = 50;
   localparam int HIGH_RESET    = 150;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WEAK_LEVEL   = 2'd2,
      CSR_STRONG_LEVEL = 2'd3
   } csr_index_type;

   // position tags carried alongside each pixel through the pipeline
   typedef struct packed {
      logic             interior;
      logic             up_ok;
      logic             left_ok;
      logic             right_ok;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] addr;
   } meta_type;

   typedef struct packed {
      logic shift;
      logic square;
   } grad_ctrl_type;

   function automatic logic [COL_W-1:0] eff_width_m1(logic [IMG_WIDTH_W-1:0] v);
      int w;
      w = int'(v);
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return COL_W'(w - 1);
   endfunction

   function automatic logic [ROW_W-1:0] eff_height_m1(logic [IMG_HEIGHT_W-1:0] v);
      if (v < IMG_HEIGHT_W'(3)) begin
         return ROW_W'(2);
      end
      return ROW_W'(v - IMG_HEIGHT_W'(1));
   endfunction

   function automatic logic [MAG_W-1:0] thresh_sq(logic [THRESH_W-1:0] t);
      logic [MAG_W-1:0] t_ext;
      t_ext = MAG_W'(t);
      return t_ext * t_ext;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sedt_if.sv
// Stream interfaces of the edge detector: pixel request and edge result channels.
// Depends on sedt_pkg for field widths.
`default_nettype none

interface sedt_req_if;
   import sedt_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface sedt_rsp_if;
   import sedt_pkg::*;
   logic                valid;
   logic                ready;
   logic                edge_res;
   logic [ROW_W-1:0]    row;
   logic [COLUMN_W-1:0] column;
   logic                last;

   modport source (output valid, output edge_res, output row, output column, output last,
                   input ready);
   modport sink   (input valid, input edge_res, input row, input column, input last,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/sedt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module sedt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/sedt_grad.sv
// 3x3 pixel window and Sobel gradient squaring stage.
// Depends on sedt_pkg.
`default_nettype none

module sedt_grad (
   input  logic                         clock,
   input  logic                         reset,
   input  sedt_pkg::grad_ctrl_type      ctrl,
   input  logic [sedt_pkg::PIXEL_W-1:0] top,
   input  logic [sedt_pkg::PIXEL_W-1:0] mid,
   input  logic [sedt_pkg::PIXEL_W-1:0] bot,
   output logic [sedt_pkg::SQ_W-1:0]    sqx,
   output logic [sedt_pkg::SQ_W-1:0]    sqy
);
   import sedt_pkg::*;

   // win_ff[row][col]: row 0 oldest line, col 0 oldest column
   logic [PIXEL_W-1:0]      win_ff [3][3];
   logic [GRAD_W-1:0]       pos_x, neg_x, pos_y, neg_y;
   logic signed [GRAD_W-1:0] gx, gy;
   logic signed [2*GRAD_W-1:0] prod_x, prod_y;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '{default: '0};
      end else if (ctrl.shift) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= top;
         win_ff[1][2] <= mid;
         win_ff[2][2] <= bot;
      end
   end

   always_comb begin
      pos_x = GRAD_W'(win_ff[0][2]) + (GRAD_W'(win_ff[1][2]) << 1) + GRAD_W'(win_ff[2][2]);
      neg_x = GRAD_W'(win_ff[0][0]) + (GRAD_W'(win_ff[1][0]) << 1) + GRAD_W'(win_ff[2][0]);
      pos_y = GRAD_W'(win_ff[2][0]) + (GRAD_W'(win_ff[2][1]) << 1) + GRAD_W'(win_ff[2][2]);
      neg_y = GRAD_W'(win_ff[0][0]) + (GRAD_W'(win_ff[0][1]) << 1) + GRAD_W'(win_ff[0][2]);
      gx = $signed(pos_x) - $signed(neg_x);
      gy = $signed(pos_y) - $signed(neg_y);
      prod_x = gx * gx;
      prod_y = gy * gy;
   end

   always_ff @(posedge clock) begin
      if (ctrl.square) begin
         sqx_ff <= prod_x[SQ_W-1:0];
         sqy_ff <= prod_y[SQ_W-1:0];
      end
   end

   assign sqx = sqx_ff;
   assign sqy = sqy_ff;

endmodule

`default_nettype wire

### hw/rtl/sobel_edge_double_threshold.sv
// Sobel edge detector with double threshold and one-pass hysteresis.
// Depends on sedt_pkg, sedt_if, sedt_ram, sedt_grad and the assertion macros header.
//
// Usage:
//   req_if carries 8-bit grayscale pixels in raster order, one per transfer.
//   rsp_if returns one result per interior pixel (edge flag, row, column,
//   last); border pixels produce no result. Results keep pixel order.
//   The csr_ port writes image width, image height and the weak and strong
//   edge levels; a geometry write restarts the frame at row 0, column 0.
// Timing:
//   One pixel per cycle sustained while rsp_if takes results. A result
//   passes the line RAM read at the transfer of the pixel that completes
//   its 3x3 window, then window, gradient square and decision/output register.
// Reset:
//   Position, thresholds and geometry return to their reset values at once.
//   The line RAMs are not cleared; only lines written in the current frame
//   are ever consulted.
// Stall:
//   While the output register waits, the empty stages behind it keep filling:
//   up to three more interior pixels are taken before req_if.ready drops, and
//   border pixels pass the decision stage without waiting.
`default_nettype none
`include "sobel_edge_double_threshold_macros.svh"

module sobel_edge_double_threshold (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sedt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sedt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   sedt_req_if.sink                         req_if,
   sedt_rsp_if.source                       rsp_if
);
   import sedt_pkg::*;

   // configuration
   logic [COL_W-1:0] weff_m1_ff;
   logic [ROW_W-1:0] heff_m1_ff;
   logic [MAG_W-1:0] lo2_ff, hi2_ff;
   logic             geom_write;

   // position of the next pixel
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;

   // pipeline
   logic               req_fire;
   logic               out_free, s1_go, s2_go, s3_go;
   meta_type           s0_meta;
   logic               s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   meta_type           s1_meta_ff, s2_meta_ff, s3_meta_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;

   // memories
   logic [LINE_W-1:0]  line_rdata;
   logic               edge_we, edge_rdata;

   // gradient and decision
   grad_ctrl_type      grad_ctrl;
   logic [SQ_W-1:0]    sqx, sqy;
   logic [MAG_W-1:0]   mag2;
   logic               nb, edge_dec;
   logic               left_ff;
   logic [1:0]         up_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_edge_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [COLUMN_W-1:0] rsp_col_ff;
   logic                rsp_last_ff;

   // ---------------- configuration ----------------
   assign geom_write = csr_we && (csr_index_type'(csr_index) == CSR_IMAGE_WIDTH ||
                                  csr_index_type'(csr_index) == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         weff_m1_ff <= eff_width_m1(IMG_WIDTH_W'(WIDTH_RESET));
         heff_m1_ff <= eff_height_m1(IMG_HEIGHT_W'(HEIGHT_RESET));
         lo2_ff     <= thresh_sq(THRESH_W'(LOW_RESET));
         hi2_ff     <= thresh_sq(THRESH_W'(HIGH_RESET));
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               weff_m1_ff <= eff_width_m1(csr_wdata[IMG_WIDTH_W-1:0]);
            end
            CSR_IMAGE_HEIGHT: begin
               heff_m1_ff <= eff_height_m1(csr_wdata[IMG_HEIGHT_W-1:0]);
            end
            CSR_WEAK_LEVEL: begin
               lo2_ff <= thresh_sq(csr_wdata[THRESH_W-1:0]);
            end
            CSR_STRONG_LEVEL: begin
               hi2_ff <= thresh_sq(csr_wdata[THRESH_W-1:0]);
            end
         endcase
      end
   end

   // ---------------- flow control ----------------
   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   // border pixels leave the decision stage without using the output register
   assign s3_go    = s3_v_ff && (!s3_meta_ff.interior || out_free);
   assign s2_go    = s2_v_ff && (!s3_v_ff || s3_go);
   assign s1_go    = s1_v_ff && (!s2_v_ff || s2_go);
   assign req_if.ready = !s1_v_ff || s1_go;

   // ---------------- position counters ----------------
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (geom_write) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (req_fire) begin
         if (col_count_ff == weff_m1_ff) begin
            col_count_in = '0;
            row_count_in = (row_count_ff == heff_m1_ff) ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s0_meta.interior = (row_count_ff >= ROW_W'(2)) && (col_count_ff >= COL_W'(2));
      s0_meta.up_ok    = row_count_ff >= ROW_W'(3);
      s0_meta.left_ok  = col_count_ff >= COL_W'(3);
      s0_meta.right_ok = col_count_ff < weff_m1_ff;
      s0_meta.last     = (row_count_ff == heff_m1_ff) && (col_count_ff == weff_m1_ff);
      s0_meta.row      = row_count_ff - ROW_W'(1);
      s0_meta.col      = col_count_ff - COL_W'(1);
      s0_meta.addr     = col_count_ff;
   end

   // ---------------- stage valids ----------------
   always_comb begin
      s1_v_in      = req_fire ? 1'b1 : (s1_go ? 1'b0 : s1_v_ff);
      s2_v_in      = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_ff);
      s3_v_in      = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_v_ff);
      rsp_valid_in = (s3_go && s3_meta_ff.interior) ? 1'b1 :
                     (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s3_go && s3_meta_ff.interior) begin
            left_ff <= edge_dec;
         end
      end
   end

   // ---------------- stage payloads ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meta_ff  <= s0_meta;
         s1_pixel_ff <= req_if.pixel;
      end
      if (s1_go) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (s2_go) begin
         s3_meta_ff <= s2_meta_ff;
      end
      if (s3_go) begin
         // slide the previous row's flags: up_ff[0] up-left, up_ff[1] up
         up_ff <= {edge_rdata, up_ff[1]};
      end
      if (s3_go && s3_meta_ff.interior) begin
         rsp_edge_ff <= edge_dec;
         rsp_row_ff  <= s3_meta_ff.row;
         rsp_col_ff  <= COLUMN_W'(s3_meta_ff.col);
         rsp_last_ff <= s3_meta_ff.last;
      end
   end

   // ---------------- line buffers ----------------
   // low byte holds row r-2, high byte row r-1; write back shifts them up
   sedt_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (s1_go),
      .waddr (s1_meta_ff.addr),
      .wdata ({s1_pixel_ff, line_rdata[LINE_W-1:PIXEL_W]}),
      .re    (req_fire),
      .raddr (col_count_ff),
      .rdata (line_rdata)
   );

   // edge flags of the previous interior row; read one column ahead
   assign edge_we = s3_go && s3_meta_ff.interior;

   sedt_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (s3_meta_ff.col),
      .wdata (edge_dec),
      .re    (s2_go),
      .raddr (s2_meta_ff.addr),
      .rdata (edge_rdata)
   );

   // ---------------- gradient ----------------
   assign grad_ctrl.shift  = s1_go;
   assign grad_ctrl.square = s2_go;

   sedt_grad u_grad (
      .clock (clock),
      .reset (reset),
      .ctrl  (grad_ctrl),
      .top   (line_rdata[PIXEL_W-1:0]),
      .mid   (line_rdata[LINE_W-1:PIXEL_W]),
      .bot   (s1_pixel_ff),
      .sqx   (sqx),
      .sqy   (sqy)
   );

   // ---------------- decision ----------------
   always_comb begin
      mag2 = MAG_W'(sqx) + MAG_W'(sqy);
      nb   = (s3_meta_ff.up_ok && ((s3_meta_ff.left_ok && up_ff[0]) || up_ff[1] ||
                                   (s3_meta_ff.right_ok && edge_rdata))) ||
             (s3_meta_ff.left_ok && left_ff);
      edge_dec = (mag2 >= hi2_ff) || ((mag2 >= lo2_ff) && nb);
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.edge_res = rsp_edge_ff;
   assign rsp_if.row      = rsp_row_ff;
   assign rsp_if.column   = rsp_col_ff;
   assign rsp_if.last     = rsp_last_ff;

   // ---------------- assertions ----------------
   `SEDT_ASSERT_IMPL(a_col_in_range, 1'b1, col_count_ff <= weff_m1_ff, "column count past width")
   `SEDT_ASSERT_IMPL(a_row_in_range, 1'b1, row_count_ff <= heff_m1_ff, "row count past height")
   `SEDT_ASSERT_NEXT(a_s3_hold, s3_v_ff && !s3_go, s3_v_ff, "decision stage dropped a pixel")
   `SEDT_ASSERT_NEXT(a_rsp_source, !rsp_valid_ff && !edge_we, !rsp_valid_ff, "stray result")

endmodule

`default_nettype wire

### dv/tb_sobel_edge_double_threshold.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Sobel double-threshold edge detector.
// Depends on sedt_pkg, the sedt_req_if/sedt_rsp_if interfaces and the RTL top.

module tb_sobel_edge_double_threshold;
   import sedt_pkg::*;

   localparam int STUCK_LIMIT      = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 8;
   localparam int END_SETTLE       = 12;
   localparam int RANDOM_PIXELS    = 350;
   localparam int WIDE_PIXELS      = 40;

   typedef struct packed {
      logic                edge_res;
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] column;
      logic                last;
   } edge_result_type;

   typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_SOFT, PIX_CHECKER} pixel_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sedt_req_if req_if();
   sedt_rsp_if rsp_if();

   sobel_edge_double_threshold dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   // predictor state: configuration, line stores, window, position
   logic [IMG_WIDTH_W-1:0]  cfg_width;
   logic [IMG_HEIGHT_W-1:0] cfg_height;
   logic [THRESH_W-1:0]     cfg_low;
   logic [THRESH_W-1:0]     cfg_high;
   logic [PIXEL_W-1:0]      line_store [2*MAX_WIDTH];
   bit                      edge_flags [MAX_WIDTH];
   logic [PIXEL_W-1:0]      win [3][3];
   bit                      left_flag;
   int                      row_pos;
   int                      col_pos;

   logic [PIXEL_W-1:0] pixel_queue [$];
   edge_result_type    expected_edges [$];

   int pixels_pushed;
   int pixels_accepted;
   int edges_predicted;
   int edges_checked;
   int edge_hits;
   int error_count;
   int stuck_cycles;
   int send_idle_pct;
   int rsp_stall_pct;
   int soft_level;
   int hold_left;
   bit hold_done;
   bit long_hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 30)
         $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   // Advance the frame by one pixel; queue a result when an interior window completes.
   function automatic bit predict_edge_decision(input logic [PIXEL_W-1:0] px);
      int w, h, r, c, mid_row, mid_col, gx, gy, mag2, lo2, hi2;
      int p [3][3];
      bit flag, near_edge, produced;
      edge_result_type res;
      w = (cfg_width < 3) ? 3 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
      h = (cfg_height < 3) ? 3 : int'(cfg_height);
      r = row_pos;
      c = col_pos;
      produced = 1'b0;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = line_store[c];
      win[1][2] = line_store[MAX_WIDTH + c];
      win[2][2] = px;
      line_store[c] = line_store[MAX_WIDTH + c];
      line_store[MAX_WIDTH + c] = px;

      if (r >= 2 && c >= 2) begin
         mid_row = r - 1;
         mid_col = c - 1;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               p[i][j] = int'(win[i][j]);
         gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
         gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
         mag2 = gx * gx + gy * gy;
         lo2 = int'(cfg_low) * int'(cfg_low);
         hi2 = int'(cfg_high) * int'(cfg_high);
         flag = 1'b0;
         if (mag2 >= hi2) begin
            flag = 1'b1;
         end else if (mag2 >= lo2) begin
            // weak: keep only when a neighbor already decided this frame is an edge
            near_edge = 1'b0;
            if (mid_row >= 2) begin
               if (mid_col >= 2 && edge_flags[mid_col - 1]) near_edge = 1'b1;
               if (edge_flags[mid_col]) near_edge = 1'b1;
               if (mid_col + 1 <= w - 2 && edge_flags[mid_col + 1]) near_edge = 1'b1;
            end
            if (mid_col >= 2 && left_flag) near_edge = 1'b1;
            flag = near_edge;
         end
         // write one behind so the up-left flag of the next pixel survives
         if (mid_col >= 2) edge_flags[mid_col - 1] = left_flag;
         if (mid_col == w - 2) edge_flags[mid_col] = flag;
         left_flag = flag;

         res.edge_res = flag;
         res.row      = ROW_W'(mid_row);
         res.column   = COLUMN_W'(mid_col);
         res.last     = (mid_row == h - 2 && mid_col == w - 2);
         expected_edges.push_back(res);
         produced = 1'b1;
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return produced;
   endfunction

   function automatic logic [PIXEL_W-1:0] make_pixel(input pixel_mode_type mode, input int idx);
      int v;
      case (mode)
         PIX_UNIFORM: v = $urandom_range(255);
         PIX_EXTREME: v = $urandom_range(1) ? 255 : 0;
         PIX_CHECKER: v = idx[0] ? 255 : 0;
         default: begin
            // smooth area with noise and occasional steps: weak gradients near strong ones
            if ($urandom_range(11) == 0) soft_level = $urandom_range(255);
            v = soft_level + int'($urandom_range(40)) - 20;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
      endcase
      return PIXEL_W'(v);
   endfunction

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH: begin
            cfg_width = IMG_WIDTH_W'(value);
            row_pos = 0;
            col_pos = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_height = IMG_HEIGHT_W'(value);
            row_pos = 0;
            col_pos = 0;
         end
         CSR_WEAK_LEVEL:   cfg_low = THRESH_W'(value);
         CSR_STRONG_LEVEL: cfg_high = THRESH_W'(value);
         default: ;
      endcase
   endtask

   task automatic push_pixels(input int count, input pixel_mode_type mode);
      @(negedge clock);
      for (int i = 0; i < count; i++)
         pixel_queue.push_back(make_pixel(mode, i));
      pixels_pushed += count;
   endtask

   task automatic wait_drained();
      while (pixels_accepted != pixels_pushed || edges_checked != edges_predicted)
         @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic write_geometry_and_thresholds(input int w, input int h, input int lo,
                                                input int hi);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_WEAK_LEVEL, lo);
      write_csr(CSR_STRONG_LEVEL, hi);
   endtask

   // sender: offer the next queued pixel, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            pixels_accepted <= pixels_accepted + 1;
            if (predict_edge_decision(req_if.pixel)) edges_predicted <= edges_predicted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.pixel <= pixel_queue.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started once on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver: check each result transfer against the oldest prediction
   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_edges.size() == 0) begin
               report_mismatch("result with no pixel pending", int'(rsp_if.row), -1);
            end else begin
               want = expected_edges.pop_front();
               edges_checked <= edges_checked + 1;
               if (rsp_if.edge_res) edge_hits <= edge_hits + 1;
               if (rsp_if.edge_res !== want.edge_res)
                  report_mismatch("edge_res", int'(rsp_if.edge_res), int'(want.edge_res));
               if (rsp_if.row !== want.row)
                  report_mismatch("row", int'(rsp_if.row), int'(want.row));
               if (rsp_if.column !== want.column)
                  report_mismatch("column", int'(rsp_if.column), int'(want.column));
               if (rsp_if.last !== want.last)
                  report_mismatch("last", int'(rsp_if.last), int'(want.last));
            end
         end
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
         $display("sobel_edge_double_threshold test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase_idx, random_pixels, count, width_val, height_val, lo, hi;
      int eff_w, eff_h, settings;
      pixel_mode_type mode;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pixel = '0;
      rsp_if.ready = 1'b0;
      cfg_width = IMG_WIDTH_W'(WIDTH_RESET);
      cfg_height = IMG_HEIGHT_W'(HEIGHT_RESET);
      cfg_low = THRESH_W'(LOW_RESET);
      cfg_high = THRESH_W'(HIGH_RESET);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
      left_flag = 1'b0;
      row_pos = 0;
      col_pos = 0;
      pixels_pushed = 0;
      pixels_accepted = 0;
      edges_predicted = 0;
      edges_checked = 0;
      edge_hits = 0;
      error_count = 0;
      stuck_cycles = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      soft_level = 128;
      long_hold_req = 1'b0;
      random_pixels = 0;
      settings = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: clamped tiny geometry, low above high, zero and full-scale thresholds
      write_geometry_and_thresholds(0, 2, 2047, 0);
      push_pixels(9, PIX_CHECKER);
      write_geometry_and_thresholds(4, 3, 0, 2047);
      push_pixels(12, PIX_EXTREME);
      settings += 2;

      // width above range (partial first row), then the tallest height setting
      write_geometry_and_thresholds(4095, 3, 300, 600);
      push_pixels(WIDE_PIXELS, PIX_UNIFORM);
      write_geometry_and_thresholds(3, 65535, 40, 120);
      push_pixels(60, PIX_SOFT);
      settings += 2;

      phase_idx = 0;
      eff_w = 3;
      eff_h = 3;
      while (random_pixels < RANDOM_PIXELS || phase_idx < 4) begin
         case (phase_idx % 4)
            0: set_idling(0, 0);
            1: set_idling(77, 0);
            2: set_idling(0, 77);
            default: set_idling(9, 9);
         endcase

         case ($urandom_range(7))
            0: begin lo = 0; hi = $urandom_range(300); end
            1: begin lo = $urandom_range(200); hi = 0; end
            2: begin lo = 2047; hi = 2047; end
            3: begin lo = $urandom_range(100, 400); hi = $urandom_range(lo); end
            default: begin lo = $urandom_range(10, 150); hi = lo + $urandom_range(400); end
         endcase

         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         // now and then keep the geometry so the frame carries on across the change
         if (phase_idx == 0 || $urandom_range(4) != 0) begin
            width_val = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            height_val = $urandom_range(6);
            eff_w = (width_val < 3) ? 3 : width_val;
            eff_h = (height_val < 3) ? 3 : height_val;
            write_csr(CSR_IMAGE_WIDTH, width_val);
            write_csr(CSR_IMAGE_HEIGHT, height_val);
         end
         write_csr(CSR_WEAK_LEVEL, lo);
         write_csr(CSR_STRONG_LEVEL, hi);
         settings++;

         if ($urandom_range(3) == 0)
            count = $urandom_range(8, 60);
         else
            count = eff_w * eff_h * $urandom_range(1, 2);
         mode = pixel_mode_type'($urandom_range(2));

         if (phase_idx == 2) begin
            // stall the receiver long enough for the block to back up its input
            if (count < 80) count = 80;
            @(negedge clock);
            long_hold_req = 1'b1;
            push_pixels(count, mode);
         end else if (phase_idx == 1) begin
            // pause the sender mid-frame until every result is back
            push_pixels(count / 2, mode);
            wait_drained();
            push_pixels(count - count / 2, mode);
         end else begin
            push_pixels(count, mode);
         end
         random_pixels += count;
         phase_idx++;
      end

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (expected_edges.size() != 0)
         report_mismatch("results never returned", 0, expected_edges.size());

      $display("covered %0d register settings, %0d pixels sent, %0d results checked",
               settings, pixels_accepted, edges_checked);
      $display("%0d results flagged as edges, %0d mismatches", edge_hits, error_count);
      if (error_count == 0) begin
         $display("sobel_edge_double_threshold test passed");
      end else begin
         $display("sobel_edge_double_threshold test failed");
      end
      $finish;
   end

endmodule
